>>> hw/rtl/pnmg_pkg.sv
// Types, codes and constants shared by the PNM stream to gray decoder
package pnmg_pkg;

  // dimension limit and accumulator sizing
  localparam int unsigned DimBits = 16;
  localparam int unsigned AccW    = ((DimBits > 16) ? DimBits : 16) + 1;
  localparam logic [AccW-1:0] DimMax  = AccW'((64'd1 << DimBits) - 64'd1);
  localparam logic [AccW-1:0] AccCap  = AccW'(64'd1 << (AccW - 1));
  localparam logic [AccW-1:0] MaxByte = AccW'(255);
  localparam logic [AccW-1:0] MaxWord = AccW'(65535);

  // header characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch4     = 8'h34;
  localparam logic [7:0] Ch5     = 8'h35;
  localparam logic [7:0] Ch6     = 8'h36;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChP     = 8'h50;

  // result status codes
  localparam logic [2:0] StPixel  = 3'd0;
  localparam logic [2:0] StFormat = 3'd1;
  localparam logic [2:0] StMax    = 3'd2;
  localparam logic [2:0] StTrunc  = 3'd3;
  localparam logic [2:0] StOver   = 3'd4;

  typedef enum logic [1:0] {
    PhHeader,
    PhBody,
    PhWait
  } phase_e;

  typedef enum logic [2:0] {
    LnStart,
    LnAfterP,
    LnScan,
    LnNum,
    LnSkip
  } line_e;

  typedef enum logic [1:0] {
    FmtNone,
    FmtP4,
    FmtP5,
    FmtP6
  } fmt_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  gray_pixel;
    logic        row_end;
    logic        frame_end;
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } out_req_t;

endpackage

>>> hw/rtl/pnm_stream_to_gray_decoder.sv
// PNM byte stream header parser and body to 8-bit gray converter
//
//  channel | direction | handshake                | request
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o  | in_req_i  (one file byte)
//  out     | output    | out_valid_o / out_stall_i| out_req_o (pixel or error)
//
// Header bytes and P5/P6 body bytes flow at one per cycle while the output register is not stalled.
// A P4 byte yields up to eight pixels, msb first, in the bit unpacker and is held until its last one is out.
// End of stream inside the body can hold the final byte for a separate truncated result.
// Reset and every end_of_stream byte return the parser to the start of a header.
// The result sits in an output register; a new byte enters in the cycle the held one finishes.
module pnm_stream_to_gray_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pnmg_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pnmg_pkg::out_req_t out_req_o
);

  localparam int unsigned AccW    = pnmg_pkg::AccW;
  localparam int unsigned DimBits = pnmg_pkg::DimBits;

  // held input request
  logic              hold_valid_q, hold_valid_d;
  pnmg_pkg::in_req_t hold_q;
  logic              hold_take, hold_done;

  // parser state
  pnmg_pkg::phase_e  phase_q, phase_d;
  pnmg_pkg::line_e   line_q, line_d;
  pnmg_pkg::fmt_e    fmt_q, fmt_d;
  logic [1:0]        pcnt_q, pcnt_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]   width_q, width_d;
  logic [AccW-1:0]   height_q, height_d;
  logic [AccW-1:0]   max_q, max_d;
  logic [DimBits-1:0] col_q, col_d;
  logic [DimBits-1:0] row_q, row_d;
  logic [2:0]        bip_q, bip_d;
  logic [9:0]        csum_q, csum_d;
  logic [2:0]        bit_q, bit_d;
  logic              trunc_q, trunc_d;

  // output register
  logic               out_valid_q, out_valid_d;
  pnmg_pkg::out_req_t out_q, out_d;
  logic               out_free;

  // per-cycle decode
  logic [7:0]      ch;
  logic            eos;
  logic            is_digit;
  logic [AccW+3:0] prod;
  logic [AccW-1:0] acc_next;
  logic            wide;
  logic [2:0]      p6_step, p6_last;
  logic [9:0]      csum_n;
  logic            pix_re, pix_fe;
  logic            pix_take;
  logic [7:0]      pix_val;
  logic            fail_fmt, store, eol, do_scan, hdr_done, clear;
  logic            emit, res_row, res_frame;
  logic [7:0]      res_gray;
  logic [2:0]      res_stat;
  logic [15:0]     res_w, res_h;

  assign ch  = hold_q.in_byte;
  assign eos = hold_q.end_of_stream;
  assign is_digit = ch inside {[pnmg_pkg::Ch0 : pnmg_pkg::Ch9]};

  // decimal accumulate with saturation
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (AccW+4)'(ch[3:0]);
  assign acc_next = (prod > (AccW+4)'(pnmg_pkg::AccCap)) ? pnmg_pkg::AccCap : prod[AccW-1:0];

  // color sample sequencing
  assign wide    = (max_q == pnmg_pkg::MaxWord);
  assign p6_step = wide ? 3'd2 : 3'd1;
  assign p6_last = wide ? 3'd5 : 3'd2;

  always_comb begin
    csum_n = csum_q;
    if (bip_q == 3'd0) begin
      csum_n = {2'b00, ch};
    end else if (bip_q == p6_step) begin
      csum_n = csum_q + {1'b0, ch, 1'b0};
    end else if (bip_q == {p6_step[1:0], 1'b0}) begin
      csum_n = csum_q + {2'b00, ch};
    end
  end

  // row and frame end of the next pixel
  assign pix_re = (AccW'(col_q) + AccW'(1)) >= width_q;
  assign pix_fe = pix_re && ((AccW'(row_q) + AccW'(1)) >= height_q);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = hold_valid_q && !hold_done;
  assign hold_take  = in_valid_i && !in_stall_o;

  // next state of the parser and the held request
  always_comb begin
    phase_d  = phase_q;
    line_d   = line_q;
    fmt_d    = fmt_q;
    pcnt_d   = pcnt_q;
    acc_d    = acc_q;
    width_d  = width_q;
    height_d = height_q;
    max_d    = max_q;
    col_d    = col_q;
    row_d    = row_q;
    bip_d    = bip_q;
    csum_d   = csum_q;
    bit_d    = bit_q;
    trunc_d  = trunc_q;
    hold_done = 1'b0;
    clear     = 1'b0;
    emit      = 1'b0;
    res_gray  = 8'h00;
    res_row   = 1'b0;
    res_frame = 1'b0;
    res_stat  = pnmg_pkg::StPixel;
    fail_fmt  = 1'b0;
    store     = 1'b0;
    eol       = 1'b0;
    do_scan   = 1'b0;
    hdr_done  = 1'b0;
    pix_take  = 1'b0;
    pix_val   = 8'h00;

    if (hold_valid_q && out_free) begin
      if (trunc_q) begin
        // truncated result after the last pixels of the final byte
        emit      = 1'b1;
        res_frame = 1'b1;
        res_stat  = pnmg_pkg::StTrunc;
        clear     = 1'b1;
        hold_done = 1'b1;
      end else begin
        case (phase_q)
          pnmg_pkg::PhHeader: begin
            hold_done = 1'b1;
            // header byte by line position
            case (line_q)
              pnmg_pkg::LnStart: begin
                if (ch == pnmg_pkg::ChHash) begin
                  line_d = pnmg_pkg::LnSkip;
                end else if (ch == pnmg_pkg::ChP && fmt_q == pnmg_pkg::FmtNone) begin
                  line_d = pnmg_pkg::LnAfterP;
                end else begin
                  do_scan = 1'b1;
                end
              end
              pnmg_pkg::LnAfterP: begin
                if (ch == pnmg_pkg::Ch4) begin
                  fmt_d  = pnmg_pkg::FmtP4;
                  line_d = pnmg_pkg::LnScan;
                end else if (ch == pnmg_pkg::Ch5) begin
                  fmt_d  = pnmg_pkg::FmtP5;
                  line_d = pnmg_pkg::LnScan;
                end else if (ch == pnmg_pkg::Ch6) begin
                  fmt_d  = pnmg_pkg::FmtP6;
                  line_d = pnmg_pkg::LnScan;
                end else begin
                  fail_fmt = 1'b1;
                end
              end
              pnmg_pkg::LnScan: begin
                do_scan = 1'b1;
              end
              pnmg_pkg::LnNum: begin
                if (is_digit) begin
                  acc_d = acc_next;
                end else begin
                  store = 1'b1;
                  if (ch == pnmg_pkg::ChNl) begin
                    eol = 1'b1;
                  end else if (ch == pnmg_pkg::ChNul || pcnt_q >= 2'd2) begin
                    line_d = pnmg_pkg::LnSkip;
                  end else begin
                    line_d = pnmg_pkg::LnScan;
                  end
                end
              end
              default: begin
                if (ch == pnmg_pkg::ChNl) begin
                  eol = 1'b1;
                end else begin
                  line_d = pnmg_pkg::LnSkip;
                end
              end
            endcase

            // blanks, digits and anything else between fields
            if (do_scan) begin
              if (ch == pnmg_pkg::ChNl) begin
                eol = 1'b1;
              end else if (ch == pnmg_pkg::ChSpace) begin
                line_d = pnmg_pkg::LnScan;
              end else if (is_digit && pcnt_q != 2'd3) begin
                acc_d  = AccW'(ch[3:0]);
                line_d = pnmg_pkg::LnNum;
              end else begin
                line_d = pnmg_pkg::LnSkip;
              end
            end

            if (fail_fmt) begin
              emit      = 1'b1;
              res_frame = 1'b1;
              res_stat  = pnmg_pkg::StFormat;
              phase_d   = pnmg_pkg::PhWait;
            end else begin
              // number complete, by delimiter or by end of stream
              if (store || (eos && line_d == pnmg_pkg::LnNum)) begin
                case (pcnt_q)
                  2'd0:    width_d  = acc_d;
                  2'd1:    height_d = acc_d;
                  2'd2:    max_d    = acc_d;
                  default: ;
                endcase
                if (pcnt_q != 2'd3) begin
                  pcnt_d = pcnt_q + 2'd1;
                end
                acc_d = '0;
              end
              if (eol || eos) begin
                line_d = pnmg_pkg::LnStart;
              end
              hdr_done = (pcnt_d == 2'd3) || (fmt_d == pnmg_pkg::FmtP4 && pcnt_d >= 2'd2);

              // header checks at the end of the closing line
              if ((eol || eos) && hdr_done) begin
                if (fmt_d == pnmg_pkg::FmtNone) begin
                  emit      = 1'b1;
                  res_frame = 1'b1;
                  res_stat  = pnmg_pkg::StFormat;
                  phase_d   = pnmg_pkg::PhWait;
                end else if (fmt_d != pnmg_pkg::FmtP4 && max_d != pnmg_pkg::MaxByte &&
                             max_d != pnmg_pkg::MaxWord) begin
                  emit      = 1'b1;
                  res_frame = 1'b1;
                  res_stat  = pnmg_pkg::StMax;
                  phase_d   = pnmg_pkg::PhWait;
                end else if (width_d > pnmg_pkg::DimMax || height_d > pnmg_pkg::DimMax) begin
                  emit      = 1'b1;
                  res_frame = 1'b1;
                  res_stat  = pnmg_pkg::StOver;
                  phase_d   = pnmg_pkg::PhWait;
                end else if (width_d == '0 || height_d == '0) begin
                  phase_d = pnmg_pkg::PhWait;
                end else begin
                  phase_d = pnmg_pkg::PhBody;
                  col_d   = '0;
                  row_d   = '0;
                  bip_d   = '0;
                  csum_d  = '0;
                  if (eos) begin
                    emit      = 1'b1;
                    res_frame = 1'b1;
                    res_stat  = pnmg_pkg::StTrunc;
                  end
                end
              end else if (eos) begin
                emit      = 1'b1;
                res_frame = 1'b1;
                res_stat  = pnmg_pkg::StTrunc;
              end
            end
            clear = eos;
          end

          pnmg_pkg::PhBody: begin
            if (fmt_q == pnmg_pkg::FmtP4) begin
              // bit unpacker, one pixel per cycle while the output is free, msb first
              if (eos && bit_q == 3'd7 && !pix_fe) begin
                emit      = 1'b1;
                res_frame = 1'b1;
                res_stat  = pnmg_pkg::StTrunc;
                clear     = 1'b1;
                hold_done = 1'b1;
              end else begin
                pix_take = 1'b1;
                pix_val  = ch[3'd7 - bit_q] ? 8'h00 : 8'hFF;
                if (pix_re || pix_fe || bit_q == 3'd7) begin
                  bit_d = '0;
                  if (eos && !pix_fe) begin
                    trunc_d = 1'b1;
                  end else begin
                    hold_done = 1'b1;
                    clear     = eos;
                  end
                end else begin
                  bit_d = bit_q + 3'd1;
                end
              end
            end else begin
              if (fmt_q == pnmg_pkg::FmtP5) begin
                // gray samples, high byte only when wide
                if (!wide) begin
                  pix_take = 1'b1;
                  pix_val  = ch;
                end else if (bip_q == 3'd0) begin
                  csum_d = {2'b00, ch};
                  bip_d  = 3'd1;
                end else begin
                  bip_d    = '0;
                  pix_take = 1'b1;
                  pix_val  = csum_q[7:0];
                end
              end else begin
                // color samples, weighted r + 2g + b
                csum_d = csum_n;
                if (bip_q >= p6_last) begin
                  bip_d    = '0;
                  pix_take = 1'b1;
                  pix_val  = csum_n[9:2];
                end else begin
                  bip_d = bip_q + 3'd1;
                end
              end
              if (eos && !(pix_take && pix_fe)) begin
                if (pix_take) begin
                  trunc_d = 1'b1;
                end else begin
                  emit      = 1'b1;
                  res_frame = 1'b1;
                  res_stat  = pnmg_pkg::StTrunc;
                  clear     = 1'b1;
                  hold_done = 1'b1;
                end
              end else begin
                hold_done = 1'b1;
                clear     = eos;
              end
            end

            // pixel result and raster position
            if (pix_take) begin
              emit      = 1'b1;
              res_gray  = pix_val;
              res_row   = pix_re;
              res_frame = pix_fe;
              res_stat  = pnmg_pkg::StPixel;
              if (pix_re) begin
                col_d = '0;
                row_d = row_q + DimBits'(1);
              end else begin
                col_d = col_q + DimBits'(1);
              end
              if (pix_fe) begin
                phase_d = pnmg_pkg::PhWait;
              end
            end
          end

          default: begin
            hold_done = 1'b1;
            clear     = eos;
          end
        endcase
      end
    end

    res_w = width_d[15:0];
    res_h = height_d[15:0];

    if (hold_done) begin
      bit_d   = '0;
      trunc_d = 1'b0;
    end

    // rearm after the final byte
    if (clear) begin
      phase_d  = pnmg_pkg::PhHeader;
      line_d   = pnmg_pkg::LnStart;
      fmt_d    = pnmg_pkg::FmtNone;
      pcnt_d   = '0;
      acc_d    = '0;
      width_d  = '0;
      height_d = '0;
      max_d    = '0;
      col_d    = '0;
      row_d    = '0;
      bip_d    = '0;
      csum_d   = '0;
    end

    hold_valid_d = hold_take ? 1'b1 : (hold_done ? 1'b0 : hold_valid_q);
  end

  // result request and output register load
  always_comb begin
    out_d.gray_pixel   = res_gray;
    out_d.row_end      = res_row;
    out_d.frame_end    = res_frame;
    out_d.status       = res_stat;
    out_d.image_width  = res_w;
    out_d.image_height = res_h;
    out_valid_d = out_free ? emit : out_valid_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= pnmg_pkg::PhHeader;
      line_q       <= pnmg_pkg::LnStart;
      fmt_q        <= pnmg_pkg::FmtNone;
      pcnt_q       <= '0;
      acc_q        <= '0;
      width_q      <= '0;
      height_q     <= '0;
      max_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      bip_q        <= '0;
      csum_q       <= '0;
      bit_q        <= '0;
      trunc_q      <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
      phase_q      <= phase_d;
      line_q       <= line_d;
      fmt_q        <= fmt_d;
      pcnt_q       <= pcnt_d;
      acc_q        <= acc_d;
      width_q      <= width_d;
      height_q     <= height_d;
      max_q        <= max_d;
      col_q        <= col_d;
      row_q        <= row_d;
      bip_q        <= bip_d;
      csum_q       <= csum_d;
      bit_q        <= bit_d;
      trunc_q      <= trunc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (hold_take) begin
      hold_q <= in_req_i;
    end
    if (out_free && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTH
  // body is entered only with a nonempty image
  a_body_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pnmg_pkg::PhBody |-> (width_q != '0) && (height_q != '0))
    else $error("body phase with empty image");

  // raster column stays inside the row
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pnmg_pkg::PhBody |-> AccW'(col_q) < width_q)
    else $error("column past image width");

  // pending truncated result belongs to a held body byte
  a_trunc_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trunc_q |-> hold_valid_q && phase_q == pnmg_pkg::PhBody)
    else $error("truncated result pending outside body");

  // unpacker mid-byte only for bitmap bodies
  a_bit_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q != 3'd0 |-> hold_valid_q && fmt_q == pnmg_pkg::FmtP4 &&
                      phase_q == pnmg_pkg::PhBody)
    else $error("bit index set outside bitmap body");
`endif

endmodule
